@@ sv/pdutx_pkg.sv @@
// ----------------------------------------------------------------------------
// pdutx_pkg
// Shared types and constants for the message table with transmit scheduling
// and receive deadline supervision.
// ----------------------------------------------------------------------------
package pdutx_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_TRIGGER = 3'd1,
    OP_CONFIRM = 3'd2,
    OP_RECEIVE = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_PERIODIC = 2'd1,
    MODE_DIRECT   = 2'd2,
    MODE_MIXED    = 2'd3
  } tx_mode_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  entry_index;
    logic [15:0] bus_pdu_id;
    logic        ok;
    logic        started;
    logic        is_tx;
    logic [1:0]  tx_mode;
    logic [15:0] period;
    logic [7:0]  repetitions;
    logic [15:0] rep_period;
    logic [15:0] timeout;
    logic        immediate;
  } in_item_t;

  typedef struct packed {
    logic        send_now;
    logic [5:0]  which_entry;
    logic [15:0] bus_pdu_out;
    logic        deadline_hit;
    logic        deadline_state;
    logic        notify;
    logic        matched;
  } out_item_t;

  // One table row: static configuration plus runtime counters.
  typedef struct packed {
    logic [15:0] bus_id;
    logic        started;
    logic        is_tx;
    logic [1:0]  tx_mode;
    logic        immediate;
    logic [15:0] period;
    logic [15:0] rep_period;
    logic [7:0]  rep_total;
    logic [15:0] deadline;
    logic [15:0] tx_cd;
    logic [7:0]  reps_left;
    logic [15:0] rep_cd;
    logic        send_req;
    logic [15:0] rx_cd;
    logic        timed_out;
  } row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_EXEC,
    ST_ZERO
  } state_t;

  typedef struct packed {
    logic cap;
    logic cnt_clr;
    logic rd_en;
    logic rd_sel_idx;
    logic exec;
    logic zero;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       idx_ok;
    logic       match;
    logic       scan_done;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ sv/pdu_tx_mode_and_rx_deadline_table_top.sv @@
// ----------------------------------------------------------------------------
// pdu_tx_mode_and_rx_deadline_table_top
// Message table with transmit-mode scheduling and receive deadline checks.
// ----------------------------------------------------------------------------
// Each transaction yields one result. Load, trigger and tick read the indexed
// row directly; confirmation and reception scan the table one row per cycle
// through the single memory read port, stopping at the lowest matching index,
// or after all ENTRIES rows when no row matches.
// One transaction is in work at a time; the result register lets the next
// one be accepted while a result waits.
module pdu_tx_mode_and_rx_deadline_table_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdutx_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pdutx_pkg::out_item_t out_data
);
  import pdutx_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pdutx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdutx_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/pdutx_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdutx_ctrl
// Sequencer: captures a transaction, selects direct read or id scan, and
// launches the row update, or a zero result, once the result register is free.
// ----------------------------------------------------------------------------
module pdutx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pdutx_pkg::dp_sts_t sts,
  output pdutx_pkg::dp_cmd_t cmd
);
  import pdutx_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap     = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (sts.op == OP_LOAD || sts.op == OP_TRIGGER || sts.op == OP_TICK) begin
          if (sts.idx_ok) begin
            cmd.rd_en      = 1'b1;
            cmd.rd_sel_idx = 1'b1;
            state_nxt      = ST_EXEC;
          end else begin
            state_nxt = ST_ZERO;
          end
        end else if (sts.op == OP_CONFIRM || sts.op == OP_RECEIVE) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_SCAN: begin
        // stop reading on a hit so the matched row stays in the read register
        priority if (sts.match) begin
          state_nxt = ST_EXEC;
        end else if (sts.scan_done) begin
          state_nxt = ST_ZERO;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (sts.out_free) begin
          cmd.zero  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ sv/pdutx_dp.sv @@
// ----------------------------------------------------------------------------
// pdutx_dp
// Datapath: row memory with valid bits, scan counter, row update logic and
// the result register.
// ----------------------------------------------------------------------------
module pdutx_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdutx_pkg::in_item_t  in_data,
  input  pdutx_pkg::dp_cmd_t   cmd,
  output pdutx_pkg::dp_sts_t   sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pdutx_pkg::out_item_t out_data
);
  import pdutx_pkg::*;

  row_t             mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  in_item_t         in_r;
  logic [CNT_W-1:0] cnt_r;
  row_t             rd_row_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_pend_r;
  logic             out_valid_r;
  out_item_t        out_r;
  logic [IDX_W-1:0] rd_addr;
  row_t             row_nxt;
  out_item_t        res;
  logic             send, hit, ntf;

  assign rd_addr = cmd.rd_sel_idx ? in_r.entry_index[IDX_W-1:0] : cnt_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cap) in_r <= in_data;
    if (cmd.rd_en) begin
      rd_row_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
      rd_idx_r <= rd_addr;
    end
    if (cmd.exec) mem[rd_idx_r] <= row_nxt;
    if (cmd.exec || cmd.zero) out_r <= cmd.exec ? res : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd_en;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.rd_en && !cmd.rd_sel_idx) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.exec) vld_r[rd_idx_r] <= 1'b1;
      if (cmd.exec || cmd.zero) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // every row has been issued once the counter reaches the table size
  assign sts.op        = in_r.op;
  assign sts.idx_ok    = 32'(in_r.entry_index) < 32'(ENTRIES);
  assign sts.match     = rd_pend_r && (rd_row_r.bus_id == in_r.bus_pdu_id);
  assign sts.scan_done = 32'(cnt_r) >= 32'(ENTRIES);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Row update and result for the operation held in in_r.
  always_comb begin
    row_nxt = rd_row_r;
    send    = 1'b0;
    hit     = 1'b0;
    ntf     = 1'b0;
    unique case (in_r.op)
      OP_LOAD: begin
        row_nxt            = '0;
        row_nxt.bus_id     = in_r.bus_pdu_id;
        row_nxt.started    = in_r.started;
        row_nxt.is_tx      = in_r.is_tx;
        row_nxt.tx_mode    = in_r.tx_mode;
        row_nxt.immediate  = in_r.immediate;
        row_nxt.period     = in_r.period;
        row_nxt.rep_period = in_r.rep_period;
        row_nxt.rep_total  = in_r.repetitions;
        row_nxt.deadline   = in_r.timeout;
        row_nxt.rx_cd      = in_r.timeout;
      end
      OP_TRIGGER: row_nxt.send_req = 1'b1;
      OP_CONFIRM: begin
        if (in_r.ok) begin
          row_nxt.reps_left = '0;
          row_nxt.send_req  = 1'b0;
        end
      end
      OP_RECEIVE: begin
        if (rd_row_r.started) begin
          row_nxt.rx_cd     = rd_row_r.deadline;
          row_nxt.timed_out = 1'b0;
          ntf               = rd_row_r.immediate;
        end
      end
      OP_TICK: begin
        if (rd_row_r.started && rd_row_r.is_tx) begin
          unique case (tx_mode_t'(rd_row_r.tx_mode))
            MODE_PERIODIC: begin
              send = (rd_row_r.tx_cd == '0);
              row_nxt.tx_cd = send ? rd_row_r.period : rd_row_r.tx_cd - 16'd1;
            end
            MODE_DIRECT: begin
              send             = rd_row_r.send_req;
              row_nxt.send_req = 1'b0;
            end
            MODE_MIXED: begin
              priority if (rd_row_r.send_req) begin
                send              = 1'b1;
                row_nxt.send_req  = 1'b0;
                row_nxt.reps_left = rd_row_r.rep_total;
                row_nxt.rep_cd    = rd_row_r.rep_period;
              end else if (rd_row_r.tx_cd == '0) begin
                send          = 1'b1;
                row_nxt.tx_cd = rd_row_r.period;
              end else begin
                row_nxt.tx_cd = rd_row_r.tx_cd - 16'd1;
              end
              if (row_nxt.reps_left != '0 && !send) begin
                if (rd_row_r.rep_cd == '0) begin
                  send              = 1'b1;
                  row_nxt.reps_left = rd_row_r.reps_left - 8'd1;
                  row_nxt.rep_cd    = rd_row_r.rep_period;
                end else begin
                  row_nxt.rep_cd = rd_row_r.rep_cd - 16'd1;
                end
              end
            end
            default: ;
          endcase
        end else if (rd_row_r.started) begin
          if (rd_row_r.deadline != '0) begin
            if (rd_row_r.rx_cd != '0) begin
              row_nxt.rx_cd = rd_row_r.rx_cd - 16'd1;
            end else if (!rd_row_r.timed_out) begin
              row_nxt.timed_out = 1'b1;
              hit               = 1'b1;
            end
          end
          ntf = !rd_row_r.immediate;
        end
      end
      default: ;
    endcase
    res                = '0;
    res.send_now       = send;
    res.which_entry    = 6'(rd_idx_r);
    res.bus_pdu_out    = row_nxt.bus_id;
    res.deadline_hit   = hit;
    res.deadline_state = row_nxt.timed_out;
    res.notify         = ntf;
    res.matched        = 1'b1;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives load, trigger, confirm, receive, tick and undefined ops into the message
// table and checks every result against a cycle-free model of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pdutx_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int HOLD_OFF_LEN   = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  pdu_tx_mode_and_rx_deadline_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Model of the table
  logic [15:0] tbl_bus[ENTRIES];
  logic        tbl_started[ENTRIES];
  logic        tbl_tx[ENTRIES];
  tx_mode_t    tbl_mode[ENTRIES];
  logic        tbl_imm[ENTRIES];
  logic [15:0] tbl_period[ENTRIES];
  logic [15:0] tbl_rper[ENTRIES];
  logic [7:0]  tbl_reps_total[ENTRIES];
  logic [15:0] tbl_deadline[ENTRIES];
  logic [15:0] tbl_tx_cd[ENTRIES];
  logic [7:0]  tbl_reps_left[ENTRIES];
  logic [15:0] tbl_rep_cd[ENTRIES];
  logic        tbl_send_req[ENTRIES];
  logic [15:0] tbl_rx_cd[ENTRIES];
  logic        tbl_timed_out[ENTRIES];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int  mismatches;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_off_cycles;
  bit  hold_off_req;
  bit  hold_off_used;

  function automatic logic tick_transmit(int e);
    logic send;
    send = 1'b0;
    case (tbl_mode[e])
      MODE_PERIODIC: begin
        if (tbl_tx_cd[e] == 0) begin
          send = 1'b1;
          tbl_tx_cd[e] = tbl_period[e];
        end else tbl_tx_cd[e]--;
      end
      MODE_DIRECT: begin
        send = tbl_send_req[e];
        tbl_send_req[e] = 1'b0;
      end
      MODE_MIXED: begin
        if (tbl_send_req[e]) begin
          send = 1'b1;
          tbl_send_req[e] = 1'b0;
          tbl_reps_left[e] = tbl_reps_total[e];
          tbl_rep_cd[e] = tbl_rper[e];
        end else if (tbl_tx_cd[e] == 0) begin
          send = 1'b1;
          tbl_tx_cd[e] = tbl_period[e];
        end else tbl_tx_cd[e]--;
        if (tbl_reps_left[e] > 0 && !send) begin
          if (tbl_rep_cd[e] == 0) begin
            send = 1'b1;
            tbl_reps_left[e]--;
            tbl_rep_cd[e] = tbl_rper[e];
          end else tbl_rep_cd[e]--;
        end
      end
      default: ;
    endcase
    return send;
  endfunction

  function automatic out_item_t table_step(in_item_t it);
    out_item_t r;
    int e;
    r = '0;
    e = -1;
    if (it.op == OP_LOAD || it.op == OP_TRIGGER || it.op == OP_TICK) begin
      e = it.entry_index;
    end else if (it.op == OP_CONFIRM || it.op == OP_RECEIVE) begin
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (tbl_bus[i] == it.bus_pdu_id) e = i;
    end
    if (e < 0) return r;
    case (it.op)
      OP_LOAD: begin
        tbl_bus[e] = it.bus_pdu_id;
        tbl_started[e] = it.started;
        tbl_tx[e] = it.is_tx;
        tbl_mode[e] = tx_mode_t'(it.tx_mode);
        tbl_imm[e] = it.immediate;
        tbl_period[e] = it.period;
        tbl_rper[e] = it.rep_period;
        tbl_reps_total[e] = it.repetitions;
        tbl_deadline[e] = it.timeout;
        tbl_tx_cd[e] = '0;
        tbl_reps_left[e] = '0;
        tbl_rep_cd[e] = '0;
        tbl_send_req[e] = 1'b0;
        tbl_rx_cd[e] = it.timeout;
        tbl_timed_out[e] = 1'b0;
      end
      OP_TRIGGER: tbl_send_req[e] = 1'b1;
      OP_CONFIRM: begin
        if (it.ok) begin
          tbl_reps_left[e] = '0;
          tbl_send_req[e] = 1'b0;
        end
      end
      OP_RECEIVE: begin
        if (tbl_started[e]) begin
          tbl_rx_cd[e] = tbl_deadline[e];
          tbl_timed_out[e] = 1'b0;
          r.notify = tbl_imm[e];
        end
      end
      default: begin
        if (tbl_started[e]) begin
          if (tbl_tx[e]) begin
            r.send_now = tick_transmit(e);
          end else begin
            if (tbl_deadline[e] > 0) begin
              if (tbl_rx_cd[e] > 0) tbl_rx_cd[e]--;
              else if (!tbl_timed_out[e]) begin
                tbl_timed_out[e] = 1'b1;
                r.deadline_hit = 1'b1;
              end
            end
            r.notify = !tbl_imm[e];
          end
        end
      end
    endcase
    r.which_entry = 6'(e);
    r.bus_pdu_out = tbl_bus[e];
    r.deadline_state = tbl_timed_out[e];
    r.matched = 1'b1;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (in_valid && !in_ready) begin
      // hold until accepted
    end else if (pending_items.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data  <= pending_items.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready       <= 1'b0;
      hold_off_cycles <= 0;
      hold_off_used   <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else if (hold_off_req && !hold_off_used) begin
      // long stall so the block fills up and blocks its input
      hold_off_cycles <= HOLD_OFF_LEN - 1;
      hold_off_used   <= 1'b1;
      out_ready       <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
      mismatches  <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(table_step(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %p", out_data);
        end else if (expected_results[0] !== out_data) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %p actual %p", expected_results[0], out_data);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  function automatic in_item_t rand_item(int n_ids);
    in_item_t it;
    it = '0;
    it.op = $urandom_range(99, 0) < 3 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
    if ($urandom_range(9, 0) < 8) begin
      it.op = $urandom_range(9, 0) < 5 ? OP_TICK : 3'($urandom_range(3, 0));
    end
    it.entry_index = 6'($urandom_range(ENTRIES - 1, 0));
    it.bus_pdu_id  = $urandom_range(99, 0) < 85 ? 16'($urandom_range(n_ids, 0))
                                                : 16'($urandom_range(65535, 0));
    it.ok          = 1'($urandom_range(1, 0));
    it.started     = $urandom_range(9, 0) < 8;
    it.is_tx       = 1'($urandom_range(1, 0));
    it.tx_mode     = 2'($urandom_range(3, 0));
    it.period      = $urandom_range(99, 0) < 90 ? 16'($urandom_range(6, 0))
                                                : 16'($urandom_range(65535, 0));
    it.repetitions = $urandom_range(99, 0) < 90 ? 8'($urandom_range(4, 0))
                                                : 8'($urandom_range(255, 0));
    it.rep_period  = $urandom_range(99, 0) < 90 ? 16'($urandom_range(4, 0))
                                                : 16'($urandom_range(65535, 0));
    it.timeout     = $urandom_range(99, 0) < 90 ? 16'($urandom_range(6, 0))
                                                : 16'($urandom_range(65535, 0));
    it.immediate   = 1'($urandom_range(1, 0));
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    in_item_t it;
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_bus[i] = '0; tbl_started[i] = 0; tbl_tx[i] = 0; tbl_mode[i] = MODE_NONE;
      tbl_imm[i] = 0; tbl_period[i] = 0; tbl_rper[i] = 0; tbl_reps_total[i] = 0;
      tbl_deadline[i] = 0; tbl_tx_cd[i] = 0; tbl_reps_left[i] = 0; tbl_rep_cd[i] = 0;
      tbl_send_req[i] = 0; tbl_rx_cd[i] = 0; tbl_timed_out[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tick unloaded entry, lookups on empty table, every op, mixed and direct modes
    it = '0; it.op = OP_TICK; it.entry_index = 6'd63; pending_items.push_back(it);
    it = '0; it.op = OP_CONFIRM; it.bus_pdu_id = 16'hFFFF; it.ok = 1'b1;
    pending_items.push_back(it);
    it = '0; it.op = OP_RECEIVE; it.bus_pdu_id = 16'h0000; pending_items.push_back(it);
    it = '0; it.op = 3'd7; pending_items.push_back(it);
    it = '1; it.op = OP_LOAD; it.entry_index = 6'd63; it.is_tx = 1'b1;
    it.tx_mode = MODE_MIXED; it.period = 16'd1; it.repetitions = 8'd2; it.rep_period = '0;
    pending_items.push_back(it);
    it.op = OP_TRIGGER; pending_items.push_back(it);
    it.op = OP_TICK; repeat (4) pending_items.push_back(it);
    it.op = OP_CONFIRM; it.ok = 1'b0; pending_items.push_back(it);
    it.op = OP_CONFIRM; it.ok = 1'b1; pending_items.push_back(it);
    it = '0; it.op = OP_LOAD; it.entry_index = 6'd1; it.bus_pdu_id = 16'h0005;
    it.started = 1'b1; it.timeout = 16'd1; pending_items.push_back(it);
    it.op = OP_TICK; repeat (3) pending_items.push_back(it);
    it.op = OP_RECEIVE; pending_items.push_back(it);
    it = '0; it.op = OP_LOAD; it.entry_index = 6'd2; it.bus_pdu_id = 16'h0005;
    it.started = 1'b0; it.immediate = 1'b1; pending_items.push_back(it);
    it.op = OP_TICK; pending_items.push_back(it);
    it = '0; it.op = OP_LOAD; it.entry_index = 6'd3; it.bus_pdu_id = 16'h0007;
    it.started = 1'b1; it.is_tx = 1'b1; it.tx_mode = MODE_DIRECT; pending_items.push_back(it);
    it.op = OP_TRIGGER; pending_items.push_back(it);
    it.op = OP_TICK; repeat (2) pending_items.push_back(it);
    wait_drained();

    // Random phases with differing idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 56 : 28) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 56 : 28) : 0;
      if (ph == 2) hold_off_req = 1'b1;
      for (int n = 0; n < 250; n++) pending_items.push_back(rand_item(12));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/pdutx_pkg.sv
sv/pdutx_ctrl.sv
sv/pdutx_dp.sv
sv/pdu_tx_mode_and_rx_deadline_table_top.sv
tb/testbench.sv
